/* hdl/bcdtse_pkg.sv */
`default_nettype none
package bcdtse_pkg;

  // Key codes carried in the opcode field
  typedef enum logic [1:0] {
    OP_LEFT  = 2'd0,
    OP_RIGHT = 2'd1,
    OP_INC   = 2'd2,
    OP_DEC   = 2'd3
  } opcode_e;

  // Clock register indexes
  localparam logic [2:0] REG_SEC   = 3'd0;
  localparam logic [2:0] REG_MIN   = 3'd1;
  localparam logic [2:0] REG_HOUR  = 3'd2;
  localparam logic [2:0] REG_WDAY  = 3'd3;
  localparam logic [2:0] REG_DATE  = 3'd4;
  localparam logic [2:0] REG_MONTH = 3'd5;
  localparam logic [2:0] REG_YEAR  = 3'd6;

  // Cursor ring positions
  localparam logic [3:0] POS_HOME     = 4'd0;
  localparam logic [3:0] POS_YEAR_T   = 4'd1;
  localparam logic [3:0] POS_YEAR_U   = 4'd2;
  localparam logic [3:0] POS_MONTH_T  = 4'd3;
  localparam logic [3:0] POS_MONTH_U  = 4'd4;
  localparam logic [3:0] POS_DATE_T   = 4'd5;
  localparam logic [3:0] POS_DATE_U   = 4'd6;
  localparam logic [3:0] POS_WDAY     = 4'd7;
  localparam logic [3:0] POS_AMPM     = 4'd8;
  localparam logic [3:0] POS_HOUR_T   = 4'd9;
  localparam logic [3:0] POS_HOUR_U   = 4'd10;
  localparam logic [3:0] POS_MIN_T    = 4'd11;
  localparam logic [3:0] POS_MIN_U    = 4'd12;
  localparam logic [3:0] POS_SEC_T    = 4'd13;
  localparam logic [3:0] POS_SEC_U    = 4'd14;
  localparam logic [3:0] RING_LEN     = 4'd15;

  // Digit limits
  localparam logic [7:0] MONTH_MAX = 8'h12;
  localparam logic [7:0] DATE_MAX  = 8'h31;
  localparam logic [7:0] WDAY_MAX  = 8'h07;
  localparam logic [7:0] MS_TOP    = 8'h50;
  localparam logic [7:0] YEAR_TOP  = 8'h90;
  localparam logic [7:0] HOUR_FLAGS = 8'h60;
  localparam logic [7:0] HOUR_HIGH  = 8'hE0;
  localparam logic [7:0] HOUR_MASK  = 8'h1F;
  localparam logic [7:0] PM_BIT     = 8'h20;

  // Current clock register bytes
  typedef struct packed {
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] date;
    logic [7:0] weekday;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } clock_regs_t;

  // Register write produced by an edit
  typedef struct packed {
    logic       valid;
    logic [2:0] index;
    logic [7:0] value;
  } reg_write_t;

  function automatic logic [7:0] tens_up(input logic [7:0] v, input logic [7:0] top);
    if ((v & 8'hF0) < top) return v + 8'h10;
    return v & 8'h0F;
  endfunction

  function automatic logic [7:0] tens_down(input logic [7:0] v, input logic [7:0] top);
    if ((v & 8'hF0) >= 8'h10) return v - 8'h10;
    return v + top;
  endfunction

  function automatic logic [7:0] units_up(input logic [7:0] v);
    if ((v & 8'h0F) < 8'h09) return v + 8'h01;
    return v & 8'hF0;
  endfunction

  function automatic logic [7:0] units_down(input logic [7:0] v);
    if ((v & 8'h0F) >= 8'h01) return v - 8'h01;
    return v + 8'h09;
  endfunction

  // Units step for month and date: stay within 1..max
  function automatic logic [7:0] units_clamp(input logic [7:0] v, input logic up,
                                             input logic [7:0] max);
    logic [7:0] r;
    if (up) begin
      if ((v & 8'h0F) < 8'h09) begin
        r = v + 8'h01;
        if (r > max) r = r & 8'hF0;
      end else begin
        r = v & 8'hF0;
        if (r == 8'h00) r = 8'h01;
      end
    end else begin
      if ((v & 8'h0F) >= 8'h01) begin
        r = v - 8'h01;
        if (r == 8'h00) r = 8'h09;
      end else begin
        r = v + 8'h09;
        if (r > max) r = max;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/bcdtse_cursor.sv */
`default_nettype none
module bcdtse_cursor
  import bcdtse_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [1:0] opcode_i,
  output logic      [3:0] cursor_o,
  output logic      [3:0] cursor_next_o
);

  logic [3:0] cursor_q;
  logic [3:0] cursor_d;

  always_comb begin
    cursor_d = cursor_q;
    case (opcode_e'(opcode_i))
      OP_LEFT: begin
        if (cursor_q >= RING_LEN) cursor_d = POS_HOME;
        else if (cursor_q == POS_HOME) cursor_d = POS_SEC_U;
        else cursor_d = cursor_q - 4'd1;
      end
      OP_RIGHT: begin
        if (cursor_q >= POS_SEC_U) cursor_d = POS_HOME;
        else cursor_d = cursor_q + 4'd1;
      end
      default: cursor_d = cursor_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= POS_HOME;
    end else if (step_i) begin
      cursor_q <= cursor_d;
    end
  end

  assign cursor_o      = cursor_q;
  assign cursor_next_o = cursor_d;

endmodule
`default_nettype wire

/* hdl/bcdtse_edit.sv */
`default_nettype none
module bcdtse_edit
  import bcdtse_pkg::*;
(
  input  wire logic [3:0]  cursor_i,
  input  wire logic [1:0]  opcode_i,
  input  wire clock_regs_t regs_i,
  output reg_write_t       write_o
);

  logic       is_edit;
  logic       up;
  logic [7:0] h;
  logic [7:0] d;
  logic [7:0] w;

  assign is_edit = (opcode_e'(opcode_i) == OP_INC) || (opcode_e'(opcode_i) == OP_DEC);
  assign up      = (opcode_e'(opcode_i) == OP_INC);

  always_comb begin
    write_o = '0;
    h = regs_i.hours;
    d = regs_i.date;
    w = regs_i.weekday;
    if (is_edit) begin
      write_o.valid = 1'b1;
      case (cursor_i)
        POS_YEAR_T: begin
          write_o.index = REG_YEAR;
          write_o.value = up ? tens_up(regs_i.year, YEAR_TOP) : tens_down(regs_i.year, YEAR_TOP);
        end
        POS_YEAR_U: begin
          write_o.index = REG_YEAR;
          write_o.value = up ? units_up(regs_i.year) : units_down(regs_i.year);
        end
        POS_MONTH_T: begin
          write_o.index = REG_MONTH;
          write_o.value = regs_i.month ^ 8'h10;
          if (write_o.value == 8'h00) write_o.value = 8'h01;
          if (write_o.value > MONTH_MAX) write_o.value = MONTH_MAX;
        end
        POS_MONTH_U: begin
          write_o.index = REG_MONTH;
          write_o.value = units_clamp(regs_i.month, up, MONTH_MAX);
        end
        POS_DATE_T: begin
          write_o.index = REG_DATE;
          if (up) begin
            if ((d & 8'hF0) < 8'h30) begin
              d = d + 8'h10;
              if (d > DATE_MAX) d = DATE_MAX;
            end else begin
              d = d & 8'h0F;
              if (d == 8'h00) d = 8'h01;
            end
          end else begin
            if ((d & 8'hF0) >= 8'h10) begin
              d = d - 8'h10;
              if (d == 8'h00) d = 8'h01;
            end else begin
              d = d + 8'h30;
              if (d > DATE_MAX) d = DATE_MAX;
            end
          end
          write_o.value = d;
        end
        POS_DATE_U: begin
          write_o.index = REG_DATE;
          write_o.value = units_clamp(regs_i.date, up, DATE_MAX);
        end
        POS_WDAY: begin
          write_o.index = REG_WDAY;
          if (up) write_o.value = (w < WDAY_MAX) ? w + 8'h01 : 8'h01;
          else    write_o.value = (w > 8'h01) ? w - 8'h01 : WDAY_MAX;
        end
        POS_AMPM: begin
          write_o.index = REG_HOUR;
          write_o.value = h ^ PM_BIT;
        end
        POS_HOUR_T: begin
          write_o.index = REG_HOUR;
          h = h ^ 8'h10;
          if ((h & HOUR_MASK) == 8'h00) h = h + 8'h01;
          if ((h & HOUR_MASK) > MONTH_MAX) h = (h & HOUR_FLAGS) + 8'h12;
          write_o.value = h;
        end
        POS_HOUR_U: begin
          write_o.index = REG_HOUR;
          if (up) begin
            if ((h & 8'h0F) < 8'h09) begin
              h = h + 8'h01;
              if ((h & HOUR_MASK) > 8'h12) h = h & 8'hF0;
            end else begin
              h = h & 8'hF0;
              if ((h & HOUR_MASK) == 8'h00) h = h + 8'h01;
            end
          end else begin
            if ((h & 8'h0F) >= 8'h01) begin
              h = h - 8'h01;
              if ((h & HOUR_MASK) == 8'h00) h = (h & HOUR_HIGH) + 8'h09;
            end else begin
              h = h + 8'h09;
              if ((h & HOUR_MASK) > 8'h12) h = (h & HOUR_HIGH) + 8'h12;
            end
          end
          write_o.value = h;
        end
        POS_MIN_T: begin
          write_o.index = REG_MIN;
          write_o.value = up ? tens_up(regs_i.minutes, MS_TOP)
                             : tens_down(regs_i.minutes, MS_TOP);
        end
        POS_MIN_U: begin
          write_o.index = REG_MIN;
          write_o.value = up ? units_up(regs_i.minutes) : units_down(regs_i.minutes);
        end
        POS_SEC_T: begin
          write_o.index = REG_SEC;
          write_o.value = up ? tens_up(regs_i.seconds, MS_TOP)
                             : tens_down(regs_i.seconds, MS_TOP);
        end
        POS_SEC_U: begin
          write_o.index = REG_SEC;
          write_o.value = up ? units_up(regs_i.seconds) : units_down(regs_i.seconds);
        end
        default: begin
          // home or the unused code: nothing to write
          write_o = '0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* hdl/bcd_clock_time_set_editor_unit.sv */
`default_nettype none
// Time-setting editor for a BCD real-time clock. Each input transaction is one key
// press (cursor left, cursor right, increment, decrement) together with the seven
// current clock register bytes; each one yields exactly one output transaction with
// the cursor position after the key and, for an edit on a digit position, the
// register index and edited BCD byte to write back. The cursor walks a ring of 15
// places (home, year, month, date, weekday, AM/PM, hour, minute, second digits) and
// resets to home. Rate: one transaction per clock cycle sustained while
// m_axis_tready stays high. The result passes from the input register through the
// result register to the master side, moving on only when that register is free.
// While the result register is full and m_axis_tready is low, the input register
// holds its item and s_axis_tready drops; s_axis_tready follows m_axis_tready
// combinationally, so a taken result frees the input side at once.
module bcd_clock_time_set_editor_unit
  import bcdtse_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [1:0] opcode, [9:2] cur_seconds, [17:10] cur_minutes, [25:18] cur_hours,
  // [33:26] cur_weekday, [41:34] cur_date, [49:42] cur_month, [57:50] cur_year,
  // [63:58] zero
  input  wire logic [63:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] cursor_position, [4] write_valid, [7:5] write_register,
  // [15:8] write_value
  output logic      [15:0] m_axis_tdata
);

  // Input register
  logic        in_valid_q;
  logic [1:0]  in_op_q;
  clock_regs_t in_regs_q;

  // Result register
  logic        out_valid_q;
  logic [3:0]  out_cursor_q;
  reg_write_t  out_write_q;

  logic        out_free;
  logic        advance;
  logic [3:0]  cursor_cur;
  logic [3:0]  cursor_next;
  reg_write_t  edit_write;

  // Move the held item into the result register when that slot is free
  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  bcdtse_cursor u_cursor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .opcode_i      (in_op_q),
    .cursor_o      (cursor_cur),
    .cursor_next_o (cursor_next)
  );

  // Edits see the cursor as it stands before this key
  bcdtse_edit u_edit (
    .cursor_i (cursor_cur),
    .opcode_i (in_op_q),
    .regs_i   (in_regs_q),
    .write_o  (edit_write)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  // Capture the payload on each accepted transaction
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q   <= s_axis_tdata[1:0];
      in_regs_q <= clock_regs_t'(s_axis_tdata[57:2]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Hold the result until taken, load the next one on advance
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_cursor_q <= cursor_next;
      out_write_q  <= edit_write;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_write_q.value, out_write_q.index, out_write_q.valid,
                          out_cursor_q};

endmodule
`default_nettype wire
